### design/mpo_pkg.sv
`default_nettype none

package mpo_pkg;

    // Default sizes
    localparam int TABLE_SIZE_DEF  = 1024;
    localparam int PHASE_BITS_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Width of one input fraction field (0.32)
    localparam int FRAC_IN_BITS = 32;

    // Interpolation weight width
    localparam int WEIGHT_BITS = 16;

    // pi in Q28
    localparam longint unsigned PI_Q28 = 64'd843314857;

    // Waveform select codes
    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_PULSE    = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    // One sine table entry, evaluated at elaboration: round(FS*sin(2*pi*i/N)),
    // magnitude clamped to FS-1, Q28 Taylor series on the first quadrant.
    function automatic longint sine_entry(input longint unsigned idx,
                                          input int unsigned tlog,
                                          input int unsigned sb);
        longint unsigned tsize;
        longint unsigned q;
        longint unsigned r;
        longint unsigned pos;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned m;
        longint unsigned fs_max;
        longint          sum;
        tsize = 64'd1 << tlog;
        q     = (64'd4 * idx) >> tlog;
        r     = (64'd4 * idx) & (tsize - 64'd1);
        pos   = q[0] ? (tsize - r) : r;
        x     = (PI_Q28 * pos) >> (tlog + 1);
        x2    = (x * x) >> 28;
        term  = x;
        sum   = longint'(x);
        term  = ((term * x2) >> 28) / 6;
        sum   = sum - longint'(term);
        term  = ((term * x2) >> 28) / 20;
        sum   = sum + longint'(term);
        term  = ((term * x2) >> 28) / 42;
        sum   = sum - longint'(term);
        term  = ((term * x2) >> 28) / 72;
        sum   = sum + longint'(term);
        term  = ((term * x2) >> 28) / 110;
        sum   = sum - longint'(term);
        term  = ((term * x2) >> 28) / 156;
        sum   = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        m      = ((longint'(unsigned'(sum)) << (sb - 1)) + (64'd1 << 27)) >> 28;
        fs_max = (64'd1 << (sb - 1)) - 64'd1;
        if (m > fs_max) begin
            m = fs_max;
        end
        return (q >= 64'd2) ? -longint'(m) : longint'(m);
    endfunction

endpackage

`default_nettype wire

### design/multiwave_phase_oscillator_core.sv
// A word accepted on s_ passes the stage 1, stage 2 and output registers, then
// appears on m_. One word per cycle while m_tready is high; the phase register
// feeds its own adder; the sine table is a dual-read ROM with registered data.
// Reset (aresetn low, synchronous): phase cleared, waveform set to sine,
// pipeline emptied. The sine table is constant and needs no fill.
`default_nettype none

module multiwave_phase_oscillator_core #(
    parameter int TABLE_SIZE  = mpo_pkg::TABLE_SIZE_DEF,
    parameter int PHASE_BITS  = mpo_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = mpo_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_M_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // waveform select
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_wr_data,
    // input words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] phase_increment, [63:32] pulse_width
    input  wire logic [63:0]          s_tdata,
    // [0] phase_reset
    input  wire logic                 s_tuser,
    input  wire logic                 s_tlast,
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [SAMPLE_BITS-1:0] sample_out, zero padded
    output logic [TDATA_M_W-1:0]      m_tdata,
    // [0] cycle_wrapped
    output logic                      m_tuser,
    output logic                      m_tlast
);

    localparam int PB        = PHASE_BITS;
    localparam int SB        = SAMPLE_BITS;
    localparam int TABLE_LOG = $clog2(TABLE_SIZE);
    localparam int FIN       = mpo_pkg::FRAC_IN_BITS;
    localparam int WB        = mpo_pkg::WEIGHT_BITS;

    localparam logic [SB-1:0] FS_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] FS_MIN = {1'b1, {(SB-1){1'b0}}};

    // ---------------------------------------------------------------
    // Sine table, constant contents built at elaboration
    // ---------------------------------------------------------------
    logic [SB-1:0] sine_rom [TABLE_SIZE];

    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
        localparam logic [SB-1:0] ENTRY =
            SB'(mpo_pkg::sine_entry(64'(g), TABLE_LOG, SB));
        assign sine_rom[g] = ENTRY;
    end

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    mpo_pkg::wave_t wave_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg <= mpo_pkg::WAVE_SINE;
        end else if (cfg_wr_en) begin
            wave_reg <= mpo_pkg::wave_t'(cfg_wr_data);
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: each stage advances when the next is free
    // ---------------------------------------------------------------
    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;
    logic adv2;
    logic adv1;

    assign adv2     = !out_valid_reg || m_tready;
    assign adv1     = !v2_reg || adv2;
    assign s_tready = !v1_reg || adv1;

    // ---------------------------------------------------------------
    // Stage 0: align fields, clear phase on request, advance accumulator
    // ---------------------------------------------------------------
    logic [PB-1:0]        phase_reg;
    logic [PB-1:0]        phase_cur;
    logic [PB:0]          phase_sum;
    logic [FIN+PB-1:0]    inc_wide;
    logic [FIN+PB-1:0]    width_wide;
    logic [PB-1:0]        inc_al;
    logic [PB-1:0]        width_al;
    logic [TABLE_LOG-1:0] idx_lo;
    logic [TABLE_LOG-1:0] idx_hi;
    logic [PB-1:0]        frac_full;
    logic                 accept_in;

    assign accept_in  = s_tvalid && s_tready;
    assign inc_wide   = {s_tdata[FIN-1:0], {PB{1'b0}}};
    assign width_wide = {s_tdata[2*FIN-1:FIN], {PB{1'b0}}};
    assign inc_al     = inc_wide[FIN+PB-1 -: PB];
    assign width_al   = width_wide[FIN+PB-1 -: PB];
    assign phase_cur  = s_tuser ? '0 : phase_reg;
    assign phase_sum  = {1'b0, phase_cur} + {1'b0, inc_al};
    assign idx_lo     = phase_cur[PB-1 -: TABLE_LOG];
    assign idx_hi     = idx_lo + TABLE_LOG'(1);
    assign frac_full  = phase_cur << TABLE_LOG;

    // advance the phase on every accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (accept_in) begin
            phase_reg <= phase_sum[PB-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 registers: table reads and carried fields
    // ---------------------------------------------------------------
    logic [SB-1:0] rom_lo_reg;
    logic [SB-1:0] rom_hi_reg;
    logic [PB-1:0] p1_reg;
    logic [PB-1:0] w1_reg;
    logic [WB-1:0] a1_reg;
    logic          wrap1_reg;
    logic          last1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_tready) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            rom_lo_reg <= sine_rom[idx_lo];
            rom_hi_reg <= sine_rom[idx_hi];
            p1_reg     <= phase_cur;
            w1_reg     <= width_al;
            a1_reg     <= frac_full[PB-1 -: WB];
            wrap1_reg  <= phase_sum[PB];
            last1_reg  <= s_tlast;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 logic: interpolation product and the other waveforms
    // ---------------------------------------------------------------
    logic signed [SB:0]      delta1;
    logic signed [SB+WB+1:0] prod1;
    logic [PB+SB-1:0]        saw_wide;
    logic [SB-1:0]           saw_v;
    logic [PB-1:0]           tri_t;
    logic [PB+SB:0]          tri_wide;
    logic [SB:0]             tri_v;
    logic [SB-1:0]           pulse_s;
    logic [SB-1:0]           saw_s;
    logic [SB-1:0]           tri_s;
    logic [SB-1:0]           alt1;

    assign delta1   = $signed({rom_hi_reg[SB-1], rom_hi_reg})
                    - $signed({rom_lo_reg[SB-1], rom_lo_reg});
    assign prod1    = $signed({1'b0, a1_reg}) * delta1;

    assign pulse_s  = (p1_reg < w1_reg) ? FS_MAX : FS_MIN;

    // saw: top bits of the phase, offset by half scale
    assign saw_wide = {p1_reg, {SB{1'b0}}};
    assign saw_v    = saw_wide[PB+SB-1 -: SB];
    assign saw_s    = {~saw_v[SB-1], saw_v[SB-2:0]};

    // triangle: fold the second half, saturate at the peak
    assign tri_t    = p1_reg[PB-1] ? (PB'(0) - p1_reg) : p1_reg;
    assign tri_wide = {tri_t, {(SB+1){1'b0}}};
    assign tri_v    = tri_wide[PB+SB -: SB+1];
    assign tri_s    = tri_v[SB] ? FS_MAX : {~tri_v[SB-1], tri_v[SB-2:0]};

    always_comb begin
        unique case (wave_reg)
            mpo_pkg::WAVE_SINE:     alt1 = '0;
            mpo_pkg::WAVE_PULSE:    alt1 = pulse_s;
            mpo_pkg::WAVE_SAW:      alt1 = saw_s;
            mpo_pkg::WAVE_TRIANGLE: alt1 = tri_s;
            default:                alt1 = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Stage 2 registers
    // ---------------------------------------------------------------
    logic signed [SB+WB+1:0] prod2_reg;
    logic [SB-1:0]           base2_reg;
    logic [SB-1:0]           alt2_reg;
    logic                    wrap2_reg;
    logic                    last2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv1) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            prod2_reg <= prod1;
            base2_reg <= rom_lo_reg;
            alt2_reg  <= alt1;
            wrap2_reg <= wrap1_reg;
            last2_reg <= last1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2 logic: round, add to base entry, saturate, select
    // ---------------------------------------------------------------
    logic signed [SB+WB+1:0] rnd2;
    logic signed [SB+WB+1:0] interp2;
    logic signed [SB+2:0]    base2_x;
    logic signed [SB+2:0]    sum2;
    logic [SB-1:0]           sine2;
    logic [SB-1:0]           sample_next;

    assign rnd2    = prod2_reg + (SB+WB+2)'(1 << (WB - 1));
    assign interp2 = rnd2 >>> WB;
    assign base2_x = {{3{base2_reg[SB-1]}}, base2_reg};
    assign sum2    = base2_x + $signed(interp2[SB+2:0]);

    // saturate when the guard bits disagree with the sign
    always_comb begin
        if ((sum2[SB+2:SB-1] == 4'b0000) || (sum2[SB+2:SB-1] == 4'b1111)) begin
            sine2 = sum2[SB-1:0];
        end else if (sum2[SB+2]) begin
            sine2 = FS_MIN;
        end else begin
            sine2 = FS_MAX;
        end
    end

    assign sample_next = (wave_reg == mpo_pkg::WAVE_SINE) ? sine2 : alt2_reg;

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [SB-1:0] sample_reg;
    logic          wrap_out_reg;
    logic          last_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv2) begin
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            sample_reg   <= sample_next;
            wrap_out_reg <= wrap2_reg;
            last_out_reg <= last2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_M_W'(sample_reg);
    assign m_tuser  = wrap_out_reg;
    assign m_tlast  = last_out_reg;

endmodule

`default_nettype wire
